>>> rtl/cqws_pkg.sv
`default_nettype none

package cqws_pkg;

	// operation codes
	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_SWAP = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_FEW   = 3'd3;
	localparam logic [2:0] ST_RANGE = 3'd4;

	// request payload
	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
		logic [3:0]         queue_position;
		logic [3:0]         steps_forward;
	} in_item_t;

	// result payload
	typedef struct packed {
		logic signed [31:0] data;
		logic [2:0]         status;
		logic [3:0]         occupancy;
	} out_item_t;

endpackage

`default_nettype wire

>>> rtl/circular_queue_with_swap_core.sv
`default_nettype none
// Enqueue, unused op and any error go from the exec step to the finish step; dequeue adds a read step.
// For a swap, the partner offset is first reduced modulo the occupancy by
// repeated compare-and-subtract (up to 8 subtractions when two entries are held), then two
// reads and two writes go through the single-read, single-write slot memory.
// One request at a time: the next is taken once the sequencer is idle again.
// Reset clears head, tail, count, sequencer and output valid; slot contents stay undefined.
module circular_queue_with_swap_core #(
	parameter int DEPTH = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire cqws_pkg::in_item_t    in_item,
	output logic                       out_valid,
	input  wire                        out_ready,
	output cqws_pkg::out_item_t        out_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = (PW > 5) ? PW : 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DEQ,
		S_MOD,
		S_ADDR_A,
		S_ADDR_B,
		S_SW_A,
		S_FINISH
	} state_t;

	state_t                state_q;
	cqws_pkg::in_item_t    req_q;
	cqws_pkg::out_item_t   out_q;
	logic                  out_valid_q;
	logic [PW-1:0]         head_q;
	logic [PW-1:0]         tail_q;
	logic [PW-1:0]         count_q;
	logic [4:0]            r_q;
	logic [PW-1:0]         a_q;
	logic [PW-1:0]         b_q;
	logic [31:0]           t_q;
	logic [31:0]           res_data_q;
	logic [2:0]            res_status_q;

	// slot memory
	logic [31:0]           mem_q [DEPTH];
	logic [31:0]           rdata_q;
	logic                  mem_we;
	logic [PW-1:0]         mem_waddr;
	logic [31:0]           mem_wdata;
	logic [PW-1:0]         mem_raddr;

	// shared slot mapping and modulo step
	logic [4:0]            slot_off;
	logic [PW:0]           slot_sum;
	logic [PW-1:0]         slot_calc;
	logic [SW-1:0]         r_ext;
	logic [SW-1:0]         cnt_ext;
	logic [SW-1:0]         qpos_ext;
	logic                  r_ge_cnt;
	logic [PW-1:0]         head_next;
	logic [PW-1:0]         tail_next;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// queue position to slot, one wrap at most
	always_comb begin
		slot_off = (state_q == S_ADDR_B) ? r_q : {1'b0, req_q.queue_position};
		slot_sum = {1'b0, head_q} + (PW+1)'(slot_off);
		if (slot_sum >= (PW+1)'(DEPTH)) begin
			slot_sum = slot_sum - (PW+1)'(DEPTH);
		end
		slot_calc = slot_sum[PW-1:0];
	end

	// compare and subtract for the partner offset
	assign r_ext    = SW'(r_q);
	assign cnt_ext  = SW'(count_q);
	assign qpos_ext = SW'(req_q.queue_position);
	assign r_ge_cnt = (r_ext >= cnt_ext);

	assign head_next = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
	assign tail_next = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = req_q.value;
		mem_raddr = head_q;
		case (state_q)
			S_EXEC: begin
				mem_we = (req_q.op == cqws_pkg::OP_ENQ) && (count_q != PW'(DEPTH - 1));
			end
			S_ADDR_A, S_ADDR_B: begin
				mem_raddr = slot_calc;
			end
			S_SW_A: begin
				mem_we    = 1'b1;
				mem_waddr = a_q;
				mem_wdata = rdata_q;
			end
			S_FINISH: begin
				mem_we    = (req_q.op == cqws_pkg::OP_SWAP) && (res_status_q == cqws_pkg::ST_OK);
				mem_waddr = b_q;
				mem_wdata = t_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			r_q          <= '0;
			a_q          <= '0;
			b_q          <= '0;
			t_q          <= '0;
			res_data_q   <= '0;
			res_status_q <= cqws_pkg::ST_OK;
		end else begin
			// the finish step sets valid itself when it hands over a result
			if (out_valid_q && out_ready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_item;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_data_q   <= '0;
					res_status_q <= cqws_pkg::ST_OK;
					state_q      <= S_FINISH;
					case (req_q.op)
						cqws_pkg::OP_ENQ: begin
							if (count_q == PW'(DEPTH - 1)) begin
								res_status_q <= cqws_pkg::ST_FULL;
							end else begin
								tail_q  <= tail_next;
								count_q <= count_q + PW'(1);
							end
						end
						cqws_pkg::OP_DEQ: begin
							if (count_q == '0) begin
								res_status_q <= cqws_pkg::ST_EMPTY;
							end else begin
								state_q <= S_DEQ;
							end
						end
						cqws_pkg::OP_SWAP: begin
							if (cnt_ext < SW'(2)) begin
								res_status_q <= cqws_pkg::ST_FEW;
							end else if (qpos_ext >= cnt_ext) begin
								res_status_q <= cqws_pkg::ST_RANGE;
							end else begin
								r_q     <= {1'b0, req_q.queue_position} +
								           {1'b0, req_q.steps_forward};
								state_q <= S_MOD;
							end
						end
						default: begin
							res_status_q <= cqws_pkg::ST_OK;
						end
					endcase
				end
				S_DEQ: begin
					res_data_q <= rdata_q;
					head_q     <= head_next;
					count_q    <= count_q - PW'(1);
					state_q    <= S_FINISH;
				end
				S_MOD: begin
					if (r_ge_cnt) begin
						r_q <= 5'(r_ext - cnt_ext);
					end else begin
						state_q <= S_ADDR_A;
					end
				end
				S_ADDR_A: begin
					a_q     <= slot_calc;
					state_q <= S_ADDR_B;
				end
				S_ADDR_B: begin
					b_q     <= slot_calc;
					t_q     <= rdata_q;
					state_q <= S_SW_A;
				end
				S_SW_A: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_q.data      <= res_data_q;
						out_q.status    <= res_status_q;
						out_q.occupancy <= 4'(count_q);
						out_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// occupancy never passes one short of the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PW'(DEPTH - 1))
		else $error("entry count past capacity");

	// a taken request closes the request side at once
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request side open while busy");

	// count drops only on a completed dequeue
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q < $past(count_q) |-> $past(state_q == S_DEQ))
		else $error("count dropped outside dequeue");

	// a new result only leaves the finish step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result raised outside finish");
`endif

endmodule

`default_nettype wire

>>> sim/circular_queue_with_swap_core_tb.sv
`default_nettype none

module circular_queue_with_swap_core_tb;

	localparam int DEPTH = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_PCT = 29;
	localparam int RANDOM_REQUESTS = 900;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	// mirror of the ring buffer and the results it is owed
	class ring_mirror;
		logic signed [31:0] slots [DEPTH];
		int unsigned head;
		int unsigned tail;
		int unsigned count;
		cqws_pkg::out_item_t owed_results [$];
		int unsigned mismatches;

		function new();
			head = 0;
			tail = 0;
			count = 0;
			mismatches = 0;
		endfunction

		// work out the result of one accepted request
		function void apply_request(input cqws_pkg::in_item_t req);
			cqws_pkg::out_item_t res;
			int unsigned partner;
			int unsigned slot_a;
			int unsigned slot_b;
			logic signed [31:0] held;
			res = '0;
			res.status = cqws_pkg::ST_OK;
			case (req.op)
				cqws_pkg::OP_ENQ: begin
					if ((tail + 1) % DEPTH == head) begin
						res.status = cqws_pkg::ST_FULL;
					end else begin
						slots[tail] = req.value;
						tail = (tail + 1) % DEPTH;
						count++;
					end
				end
				cqws_pkg::OP_DEQ: begin
					if (count == 0) begin
						res.status = cqws_pkg::ST_EMPTY;
					end else begin
						res.data = slots[head];
						head = (head + 1) % DEPTH;
						count--;
					end
				end
				cqws_pkg::OP_SWAP: begin
					if (count < 2) begin
						res.status = cqws_pkg::ST_FEW;
					end else if (req.queue_position >= count) begin
						res.status = cqws_pkg::ST_RANGE;
					end else begin
						// partner wraps around the occupied part only
						partner = (req.queue_position + req.steps_forward) % count;
						slot_a = (head + req.queue_position) % DEPTH;
						slot_b = (head + partner) % DEPTH;
						held = slots[slot_a];
						slots[slot_a] = slots[slot_b];
						slots[slot_b] = held;
					end
				end
				default: begin
					// unused op code leaves everything alone
				end
			endcase
			res.occupancy = count[3:0];
			owed_results.push_back(res);
		endfunction

		// compare one result with the oldest one owed
		function void check_result(input cqws_pkg::out_item_t got);
			cqws_pkg::out_item_t want;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: data=%0d status=%0d occupancy=%0d",
						got.data, got.status, got.occupancy);
				return;
			end
			want = owed_results.pop_front();
			if (got.data !== want.data || got.status !== want.status
					|| got.occupancy !== want.occupancy) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected data=%0d status=%0d occupancy=%0d,",
						want.data, want.status, want.occupancy,
						" got data=%0d status=%0d occupancy=%0d",
						got.data, got.status, got.occupancy);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cqws_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	cqws_pkg::out_item_t out_item;

	bit steady = 1'b0;
	int unsigned quiet_cycles = 0;
	ring_mirror mirror;

	circular_queue_with_swap_core #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls at random outside the steady stretch
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			mirror.check_result(out_item);
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("circular_queue_with_swap_core verification failed");
			$finish;
		end
	end

	function automatic cqws_pkg::in_item_t make_request(input logic [1:0] op,
			input logic [31:0] value, input logic [3:0] qpos, input logic [3:0] fwd);
		cqws_pkg::in_item_t req;
		req.op = op;
		req.value = value;
		req.queue_position = qpos;
		req.steps_forward = fwd;
		return req;
	endfunction

	// random request, leaning toward filling or draining the queue
	function automatic cqws_pkg::in_item_t random_request(input bit filling);
		cqws_pkg::in_item_t req;
		int unsigned roll;
		req = make_request(cqws_pkg::OP_ENQ, $urandom(), 4'($urandom_range(15)),
			4'($urandom_range(15)));
		roll = $urandom_range(99);
		if (roll < 3) begin
			req.op = OP_UNUSED;
		end else if (roll < 20) begin
			req.op = cqws_pkg::OP_SWAP;
			// mostly a legal position, sometimes anything
			if (mirror.count > 0 && $urandom_range(9) != 0)
				req.queue_position = 4'($urandom_range(mirror.count - 1));
		end else if (roll < (filling ? 75 : 45)) begin
			req.op = cqws_pkg::OP_ENQ;
		end else begin
			req.op = cqws_pkg::OP_DEQ;
		end
		return req;
	endfunction

	// hold one request until it is taken, with random gaps before it
	task automatic send_request(input cqws_pkg::in_item_t req);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		mirror.apply_request(req);
	endtask

	initial begin
		bit filling;
		mirror = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty and near-empty corner cases
		send_request(make_request(cqws_pkg::OP_DEQ, 32'h0, 4'd0, 4'd0));
		send_request(make_request(cqws_pkg::OP_SWAP, 32'h0, 4'd0, 4'd0));
		send_request(make_request(cqws_pkg::OP_ENQ, 32'h8000_0000, 4'd0, 4'd0));
		send_request(make_request(cqws_pkg::OP_SWAP, 32'h0, 4'd0, 4'd1));
		send_request(make_request(cqws_pkg::OP_ENQ, 32'h7fff_ffff, 4'd0, 4'd0));
		send_request(make_request(cqws_pkg::OP_SWAP, 32'h0, 4'd2, 4'd0));
		// two entries and the longest partner walk
		send_request(make_request(cqws_pkg::OP_SWAP, 32'h0, 4'd1, 4'd15));
		send_request(make_request(OP_UNUSED, 32'hffff_ffff, 4'd15, 4'd15));
		send_request(make_request(cqws_pkg::OP_DEQ, 32'h0, 4'd0, 4'd0));
		// fill up, then overflow
		repeat (14)
			send_request(make_request(cqws_pkg::OP_ENQ, $urandom(), 4'd0, 4'd0));
		send_request(make_request(cqws_pkg::OP_ENQ, 32'h1234_5678, 4'd0, 4'd0));
		// partner lands on itself, then a position past the end
		send_request(make_request(cqws_pkg::OP_SWAP, 32'h0, 4'd14, 4'd15));
		send_request(make_request(cqws_pkg::OP_SWAP, 32'h0, 4'd15, 4'd1));

		// random traffic with fill and drain phases picked at random
		filling = 1'b0;
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 50 == 0)
				filling = 1'($urandom_range(1));
			steady <= (i >= 400 && i < 550);
			send_request(random_request(filling));
		end
		in_valid <= 1'b0;

		while (mirror.owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.owed_results.size() == 0)
			$display("circular_queue_with_swap_core verification clean");
		else
			$display("circular_queue_with_swap_core verification failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/cqws_pkg.sv
rtl/circular_queue_with_swap_core.sv
sim/circular_queue_with_swap_core_tb.sv
